FILE: src/smalu_pkg.sv
package smalu_pkg;

   localparam int MagWidth  = 15;
   localparam int WordWidth = MagWidth + 1;

   localparam logic [WordWidth-1:0] SignBit = 16'h8000;
   localparam logic [MagWidth-1:0]  MagMax  = 15'h7FFF;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_REM = 3'd4,
      CMD_CMP = 3'd5
   } cmd_type;

   localparam logic [1:0] ORD_EQ = 2'd0;
   localparam logic [1:0] ORD_GT = 2'd1;
   localparam logic [1:0] ORD_LT = 2'd2;

   // one pipeline slot, handed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 is_rem;
      logic                 sign;
      logic [MagWidth-1:0]  divisor;
      logic [MagWidth-1:0]  dividend;
      logic [MagWidth-1:0]  remainder;
      logic [MagWidth-1:0]  quotient;
      logic [WordWidth-1:0] word;
      logic                 overflow;
      logic                 div_zero;
      logic [1:0]           order;
   } stage_type;

endpackage

FILE: src/smalu_front.sv
module smalu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [2:0]            command,
   input  logic [15:0]           operand_a,
   input  logic [15:0]           operand_b,
   output smalu_pkg::stage_type  out_stage
);
   import smalu_pkg::*;

   stage_type stage_ff, stage_in;

   logic                 sa, sb, sb_eff;
   logic [MagWidth-1:0]  ma, mb, pos, neg;
   logic [WordWidth-1:0] sum, sum_word;
   logic                 sum_ovf;
   logic [2*MagWidth-1:0] prod;
   logic [1:0]           ord;

   always_comb begin
      sa = operand_a[WordWidth-1];
      sb = operand_b[WordWidth-1];
      ma = operand_a[MagWidth-1:0];
      mb = operand_b[MagWidth-1:0];
      sb_eff = (command == CMD_SUB) ? ~sb : sb;

      // signed magnitude add, subtract folds into it with b's sign flipped
      sum = {1'b0, ma} + {1'b0, mb};
      pos = sa ? mb : ma;
      neg = sa ? ma : mb;
      sum_ovf = 1'b0;
      if (sa == sb_eff) begin
         sum_ovf  = sum[WordWidth-1];
         sum_word = sum_ovf ? '0 : (sum | (sa ? SignBit : '0));
      end else if (neg > pos) begin
         sum_word = {1'b1, neg - pos};
      end else begin
         sum_word = {1'b0, pos - neg};
      end

      prod = ma * mb;

      if (operand_a == operand_b)
         ord = ORD_EQ;
      else if (sa && sb)
         ord = (ma < mb) ? ORD_GT : ORD_LT;
      else if (sa)
         ord = ORD_LT;
      else if (sb)
         ord = ORD_GT;
      else
         ord = (ma > mb) ? ORD_GT : ORD_LT;
   end

   always_comb begin
      stage_in           = '0;
      stage_in.valid     = in_valid;
      stage_in.divisor   = mb;
      stage_in.dividend  = ma;
      case (command)
         CMD_ADD, CMD_SUB: begin
            stage_in.word     = sum_word;
            stage_in.overflow = sum_ovf;
         end
         CMD_MUL: begin
            if (prod[2*MagWidth-1:MagWidth] != '0) begin
               stage_in.overflow = 1'b1;
            end else begin
               stage_in.word = {sa ^ sb, prod[MagWidth-1:0]};
            end
         end
         CMD_DIV: begin
            stage_in.div_zero = (mb == '0);
            stage_in.is_div   = (mb != '0);
            stage_in.sign     = sa ^ sb;
         end
         CMD_REM: begin
            stage_in.div_zero = (mb == '0);
            stage_in.is_rem   = (mb != '0);
            stage_in.sign     = sa & ~sb;
         end
         CMD_CMP: begin
            stage_in.order = ord;
         end
         default: begin
            stage_in.word = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

FILE: src/smalu_div_cell.sv
module smalu_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  smalu_pkg::stage_type  in_stage,
   output smalu_pkg::stage_type  out_stage
);
   import smalu_pkg::*;

   stage_type           stage_ff, stage_in;
   logic [MagWidth:0]   trial;

   // one restoring division step: bring down the next dividend bit
   always_comb begin
      stage_in = in_stage;
      trial    = {in_stage.remainder, in_stage.dividend[MagWidth-1]};
      stage_in.dividend = {in_stage.dividend[MagWidth-2:0], 1'b0};
      if (trial >= {1'b0, in_stage.divisor}) begin
         stage_in.remainder = MagWidth'(trial - {1'b0, in_stage.divisor});
         stage_in.quotient  = {in_stage.quotient[MagWidth-2:0], 1'b1};
      end else begin
         stage_in.remainder = trial[MagWidth-1:0];
         stage_in.quotient  = {in_stage.quotient[MagWidth-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_stage = stage_ff;

endmodule

FILE: src/sign_magnitude_alu16_top.sv
// pipeline: an accepted req beat passes the front cell, 15 divide cells at one quotient bit
// each and the output register before rsp_tvalid rises
// throughput: one beat per cycle unless the skid is full; every command uses the same cell row
// req_tready is registered; a two-entry output skid holds results while rsp_tready is low
// synchronous active-high reset empties the cell row and the output stage
module sign_magnitude_alu16_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // command[2:0], operand_a[18:3], operand_b[34:19], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // result_word[15:0], overflow[16], divide_by_zero[17],
                                    // order[19:18], zero
);
   import smalu_pkg::*;

   stage_type chain [MagWidth+1];

   logic        advance;
   logic [19:0] last_res;
   logic [19:0] out_data_ff, skid_data_ff;
   logic        out_valid_ff, skid_valid_ff;

   assign advance    = ~skid_valid_ff;
   assign req_tready = advance;

   smalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_tvalid),
      .command   (req_tdata[2:0]),
      .operand_a (req_tdata[18:3]),
      .operand_b (req_tdata[34:19]),
      .out_stage (chain[0])
   );

   for (genvar i = 0; i < MagWidth; i++) begin : g_cell
      smalu_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_stage  (chain[i]),
         .out_stage (chain[i+1])
      );
   end

   always_comb begin
      last_res = {chain[MagWidth].order, chain[MagWidth].div_zero,
                  chain[MagWidth].overflow, chain[MagWidth].word};
      if (chain[MagWidth].is_div)
         last_res[15:0] = {chain[MagWidth].sign, chain[MagWidth].quotient};
      else if (chain[MagWidth].is_rem)
         last_res[15:0] = {chain[MagWidth].sign, chain[MagWidth].remainder};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!out_valid_ff || rsp_tready) begin
         out_data_ff  <= last_res;
         out_valid_ff <= chain[MagWidth].valid;
      end else if (chain[MagWidth].valid) begin
         skid_data_ff  <= last_res;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_data_ff};

endmodule
